### hdl/fmbq_pkg.sv
// ----------------------------------------------------------------------------
// fmbq_pkg
// Shared types and constants for the front/middle/back queue.
// ----------------------------------------------------------------------------
package fmbq_pkg;

    localparam int MODE_W   = 3;
    localparam int DATA_W   = 32;
    localparam int STATUS_W = 2;

    // popped value reported for a pop on an empty queue
    localparam logic signed [DATA_W-1:0] POPPED_EMPTY = -32'sd1;

    typedef enum logic [MODE_W-1:0] {
        MODE_PUSH_FRONT  = 3'd0,
        MODE_PUSH_MIDDLE = 3'd1,
        MODE_PUSH_BACK   = 3'd2,
        MODE_POP_FRONT   = 3'd3,
        MODE_POP_MIDDLE  = 3'd4,
        MODE_POP_BACK    = 3'd5
    } t_mode;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE  = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef enum logic {
        S_IDLE  = 1'b0,
        S_WRITE = 1'b1
    } t_state;

endpackage

### hdl/fmbq_if.sv
// ----------------------------------------------------------------------------
// fmbq_if
// Valid/ready channels of the queue: request words in, result words out.
// ----------------------------------------------------------------------------
interface fmbq_in_if;
    logic                                  valid;
    logic                                  ready;
    logic [fmbq_pkg::MODE_W-1:0]           mode;
    logic signed [fmbq_pkg::DATA_W-1:0]    value;

    modport source (output valid, output mode, output value, input ready);
    modport sink   (input valid, input mode, input value, output ready);
endinterface

interface fmbq_out_if #(
    parameter int OCC_W = 11
);
    logic                                  valid;
    logic                                  ready;
    logic signed [fmbq_pkg::DATA_W-1:0]    popped;
    logic [fmbq_pkg::STATUS_W-1:0]         status;
    logic [OCC_W-1:0]                      occupancy;

    modport source (output valid, output popped, output status, output occupancy,
                    input ready);
    modport sink   (input valid, input popped, input status, input occupancy,
                    output ready);
endinterface

### hdl/front_middle_back_queue.sv
// ----------------------------------------------------------------------------
// front_middle_back_queue
// The two half rings are read at the accept edge; the write-back and the result
// word are registered when the WRITE state commits. The block takes no new
// request until that write-back is done; a result word held by the sink holds
// the write-back and the input with it.
// Reset (sync, active low) empties the queue; ring contents are not cleared.
// ----------------------------------------------------------------------------
module front_middle_back_queue #(
    parameter int CAPACITY = 1024
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    fmbq_in_if.sink   i_in,
    fmbq_out_if.source o_out
);

    localparam int HALF  = (CAPACITY + 1) / 2;
    localparam int IDX_W = (HALF > 1) ? $clog2(HALF) : 1;
    localparam int CNT_W = $clog2(HALF + 1);
    localparam int OCC_W = $clog2(CAPACITY + 1);
    localparam int SUM_W = ((IDX_W > CNT_W) ? IDX_W : CNT_W) + 1;
    localparam int DW    = fmbq_pkg::DATA_W;

    // ring index helpers (modulo HALF)
    function automatic logic [IDX_W-1:0] f_inc(input logic [IDX_W-1:0] a);
        return (a == IDX_W'(HALF - 1)) ? '0 : a + 1'b1;
    endfunction

    function automatic logic [IDX_W-1:0] f_dec(input logic [IDX_W-1:0] a);
        return (a == '0) ? IDX_W'(HALF - 1) : a - 1'b1;
    endfunction

    function automatic logic [IDX_W-1:0] f_slot(input logic [IDX_W-1:0] a,
                                                input logic [CNT_W-1:0] n);
        logic [SUM_W-1:0] sum;
        sum = SUM_W'(a) + SUM_W'(n);
        if (sum >= SUM_W'(HALF)) begin
            sum = sum - SUM_W'(HALF);
        end
        return sum[IDX_W-1:0];
    endfunction

    // control state
    fmbq_pkg::t_state r_state, n_state;
    logic [IDX_W-1:0] r_fh, n_fh, r_bh, n_bh;
    logic [CNT_W-1:0] r_fc, n_fc, r_bc, n_bc;
    logic             r_out_valid;

    // request and result words
    logic [fmbq_pkg::MODE_W-1:0]   r_mode;
    logic signed [DW-1:0]          r_value;
    logic signed [DW-1:0]          r_popped;
    logic [fmbq_pkg::STATUS_W-1:0] r_status;
    logic [OCC_W-1:0]              r_occ;

    // half rings
    logic [DW-1:0] f_mem [HALF];
    logic [DW-1:0] b_mem [HALF];
    logic [DW-1:0] r_f_rd, r_b_rd;

    logic                        accept, commit;
    logic [fmbq_pkg::MODE_W-1:0] w_mode;
    logic [OCC_W-1:0]            total;
    logic                        is_full, is_empty;
    logic                        f2b, b2f, pop_from_back;
    logic                        f_we, f_wfirst, f_wlast_dec, f_wdata_val;
    logic                        b_we, b_wfirst;
    logic [IDX_W-1:0]            f_rd_addr, b_rd_addr, f_wr_addr, b_wr_addr;
    logic [DW-1:0]               f_wdata, b_wdata;
    logic signed [DW-1:0]        popped;
    logic [fmbq_pkg::STATUS_W-1:0] status;

    // ---------------- state machine ----------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            fmbq_pkg::S_IDLE: begin
                if (i_in.valid) n_state = fmbq_pkg::S_WRITE;
            end
            fmbq_pkg::S_WRITE: begin
                if (!r_out_valid || o_out.ready) n_state = fmbq_pkg::S_IDLE;
            end
            default: n_state = fmbq_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        i_in.ready = (r_state == fmbq_pkg::S_IDLE);
        accept     = i_in.valid && (r_state == fmbq_pkg::S_IDLE);
        commit     = (r_state == fmbq_pkg::S_WRITE) && (!r_out_valid || o_out.ready);
    end

    // reads are planned from the incoming mode, write-back from the held one;
    // counts and heads stay put from the accept until the write-back
    assign w_mode = (r_state == fmbq_pkg::S_IDLE) ? i_in.mode : r_mode;
    assign total  = OCC_W'(r_fc) + OCC_W'(r_bc);

    always_comb begin
        f2b           = 1'b0;
        b2f           = 1'b0;
        pop_from_back = 1'b0;
        f_we          = 1'b0;
        f_wfirst      = 1'b0;
        f_wlast_dec   = 1'b0;
        f_wdata_val   = 1'b1;
        b_we          = 1'b0;
        b_wfirst      = 1'b0;
        n_fh          = r_fh;
        n_bh          = r_bh;
        n_fc          = r_fc;
        n_bc          = r_bc;
        is_full  = (w_mode == fmbq_pkg::MODE_PUSH_FRONT ||
                    w_mode == fmbq_pkg::MODE_PUSH_MIDDLE ||
                    w_mode == fmbq_pkg::MODE_PUSH_BACK) && (total >= OCC_W'(CAPACITY));
        is_empty = (w_mode == fmbq_pkg::MODE_POP_FRONT ||
                    w_mode == fmbq_pkg::MODE_POP_MIDDLE ||
                    w_mode == fmbq_pkg::MODE_POP_BACK) && (total == '0);
        if (!is_full && !is_empty) begin
            case (w_mode)
                fmbq_pkg::MODE_PUSH_FRONT: begin
                    f2b      = (r_fc > r_bc);
                    f_we     = 1'b1;
                    f_wfirst = 1'b1;
                    n_fh     = f_dec(r_fh);
                    if (f2b) begin
                        b_we     = 1'b1;
                        b_wfirst = 1'b1;
                        n_bh     = f_dec(r_bh);
                        n_bc     = r_bc + 1'b1;
                    end else begin
                        n_fc = r_fc + 1'b1;
                    end
                end
                fmbq_pkg::MODE_PUSH_MIDDLE: begin
                    f2b         = (r_fc > r_bc);
                    f_we        = 1'b1;
                    f_wlast_dec = f2b;
                    if (f2b) begin
                        b_we     = 1'b1;
                        b_wfirst = 1'b1;
                        n_bh     = f_dec(r_bh);
                        n_bc     = r_bc + 1'b1;
                    end else begin
                        n_fc = r_fc + 1'b1;
                    end
                end
                fmbq_pkg::MODE_PUSH_BACK: begin
                    if (r_bc == r_fc && r_bc == '0) begin
                        f_we = 1'b1;
                        n_fc = r_fc + 1'b1;
                    end else if (r_bc == r_fc) begin
                        // back head moves to the front tail, new word at back tail
                        b2f         = 1'b1;
                        f_we        = 1'b1;
                        f_wdata_val = 1'b0;
                        b_we        = 1'b1;
                        n_bh        = f_inc(r_bh);
                        n_fc        = r_fc + 1'b1;
                    end else begin
                        b_we = 1'b1;
                        n_bc = r_bc + 1'b1;
                    end
                end
                fmbq_pkg::MODE_POP_FRONT: begin
                    b2f  = (r_fc <= r_bc);
                    n_fh = f_inc(r_fh);
                    if (b2f) begin
                        f_we        = 1'b1;
                        f_wdata_val = 1'b0;
                        n_bh        = f_inc(r_bh);
                        n_bc        = r_bc - 1'b1;
                    end else begin
                        n_fc = r_fc - 1'b1;
                    end
                end
                fmbq_pkg::MODE_POP_MIDDLE: begin
                    b2f = (r_fc <= r_bc);
                    if (b2f) begin
                        f_we        = 1'b1;
                        f_wdata_val = 1'b0;
                        f_wlast_dec = 1'b1;
                        n_bh        = f_inc(r_bh);
                        n_bc        = r_bc - 1'b1;
                    end else begin
                        n_fc = r_fc - 1'b1;
                    end
                end
                fmbq_pkg::MODE_POP_BACK: begin
                    if (r_bc == '0) begin
                        n_fc = r_fc - 1'b1;
                    end else begin
                        pop_from_back = 1'b1;
                        f2b           = (r_fc > r_bc);
                        if (f2b) begin
                            b_we     = 1'b1;
                            b_wfirst = 1'b1;
                            n_bh     = f_dec(r_bh);
                            n_fc     = r_fc - 1'b1;
                        end else begin
                            n_bc = r_bc - 1'b1;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // addresses and write data
    always_comb begin
        f_rd_addr = (w_mode == fmbq_pkg::MODE_POP_FRONT) ? r_fh : f_slot(r_fh, r_fc - 1'b1);
        b_rd_addr = (w_mode == fmbq_pkg::MODE_POP_BACK) ? f_slot(r_bh, r_bc - 1'b1) : r_bh;
        f_wr_addr = f_wfirst ? f_dec(r_fh)
                             : f_slot(r_fh, f_wlast_dec ? r_fc - 1'b1 : r_fc);
        b_wr_addr = b_wfirst ? f_dec(r_bh) : f_slot(r_bh, r_bc);
        f_wdata   = f_wdata_val ? r_value : r_b_rd;
        b_wdata   = b_wfirst ? r_f_rd : r_value;
    end

    // result word
    always_comb begin
        popped = '0;
        status = fmbq_pkg::ST_DONE;
        if (is_full) begin
            status = fmbq_pkg::ST_FULL;
        end else if (is_empty) begin
            popped = fmbq_pkg::POPPED_EMPTY;
            status = fmbq_pkg::ST_EMPTY;
        end else if (w_mode == fmbq_pkg::MODE_POP_FRONT ||
                     w_mode == fmbq_pkg::MODE_POP_MIDDLE) begin
            popped = r_f_rd;
        end else if (w_mode == fmbq_pkg::MODE_POP_BACK) begin
            popped = pop_from_back ? r_b_rd : r_f_rd;
        end
    end

    // ---------------- memories ----------------
    // reads happen only in IDLE and write-backs only in WRITE, so a read never
    // meets a write-back in the same cycle and no forwarding path is needed
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_f_rd <= f_mem[f_rd_addr];
        end
        if (commit && f_we) begin
            f_mem[f_wr_addr] <= f_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_b_rd <= b_mem[b_rd_addr];
        end
        if (commit && b_we) begin
            b_mem[b_wr_addr] <= b_wdata;
        end
    end

    // ---------------- registers ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= fmbq_pkg::S_IDLE;
            r_fh        <= '0;
            r_bh        <= '0;
            r_fc        <= '0;
            r_bc        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (commit) begin
                r_fh        <= n_fh;
                r_bh        <= n_bh;
                r_fc        <= n_fc;
                r_bc        <= n_bc;
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_mode  <= i_in.mode;
            r_value <= i_in.value;
        end
        if (commit) begin
            r_popped <= popped;
            r_status <= status;
            r_occ    <= OCC_W'(n_fc) + OCC_W'(n_bc);
        end
    end

    assign o_out.valid     = r_out_valid;
    assign o_out.popped    = r_popped;
    assign o_out.status    = r_status;
    assign o_out.occupancy = r_occ;

endmodule

### bench/fmbq_monitor.sv
// ----------------------------------------------------------------------------
// fmbq_monitor
// Passive checker for the front/middle/back queue. It watches both channels,
// keeps its own two-half model of the queue to work out each result word,
// and compares every result word against the oldest expected one.
// ----------------------------------------------------------------------------
module fmbq_monitor #(
    parameter int CAPACITY = 1024,
    parameter int OCC_W    = 11
) (
    input  logic i_clk,
    input  logic i_rst_n,
    fmbq_in_if   i_in,
    fmbq_out_if  i_out,
    output int   o_fail_count,
    output int   o_pending,
    output int   o_level
);

    typedef struct packed {
        logic signed [fmbq_pkg::DATA_W-1:0] popped;
        logic [fmbq_pkg::STATUS_W-1:0]      status;
        logic [OCC_W-1:0]                   occupancy;
    } t_result;

    // front half holds ceil(n/2) words; its last entry is the middle
    logic signed [fmbq_pkg::DATA_W-1:0] front_half[$];
    logic signed [fmbq_pkg::DATA_W-1:0] back_half[$];
    t_result                            expected_results[$];

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        o_level      = 0;
    end

    task automatic report(input string msg);
        $display("[%0t] %s", $time, msg);
        o_fail_count++;
    endtask

    task automatic apply_request(input logic [fmbq_pkg::MODE_W-1:0] mode,
                                 input logic signed [fmbq_pkg::DATA_W-1:0] value,
                                 output t_result res);
        int total;
        total         = front_half.size() + back_half.size();
        res.popped    = '0;
        res.status    = fmbq_pkg::ST_DONE;
        if (mode <= fmbq_pkg::MODE_PUSH_BACK && total >= CAPACITY) begin
            res.status = fmbq_pkg::ST_FULL;
        end else if (mode >= fmbq_pkg::MODE_POP_FRONT && mode <= fmbq_pkg::MODE_POP_BACK &&
                     total == 0) begin
            res.popped = fmbq_pkg::POPPED_EMPTY;
            res.status = fmbq_pkg::ST_EMPTY;
        end else begin
            case (mode)
                fmbq_pkg::MODE_PUSH_FRONT, fmbq_pkg::MODE_PUSH_MIDDLE: begin
                    // make room in the front half before the push
                    if (front_half.size() > back_half.size()) begin
                        back_half.insert(0, front_half[front_half.size() - 1]);
                        front_half.delete(front_half.size() - 1);
                    end
                    if (mode == fmbq_pkg::MODE_PUSH_FRONT)
                        front_half.insert(0, value);
                    else
                        front_half.insert(front_half.size(), value);
                end
                fmbq_pkg::MODE_PUSH_BACK: begin
                    if (back_half.size() == front_half.size() && back_half.size() == 0) begin
                        front_half.insert(front_half.size(), value);
                    end else begin
                        if (back_half.size() == front_half.size()) begin
                            front_half.insert(front_half.size(), back_half[0]);
                            back_half.delete(0);
                        end
                        back_half.insert(back_half.size(), value);
                    end
                end
                fmbq_pkg::MODE_POP_FRONT, fmbq_pkg::MODE_POP_MIDDLE: begin
                    if (mode == fmbq_pkg::MODE_POP_FRONT) begin
                        res.popped = front_half[0];
                        front_half.delete(0);
                    end else begin
                        res.popped = front_half[front_half.size() - 1];
                        front_half.delete(front_half.size() - 1);
                    end
                    if (front_half.size() < back_half.size()) begin
                        front_half.insert(front_half.size(), back_half[0]);
                        back_half.delete(0);
                    end
                end
                fmbq_pkg::MODE_POP_BACK: begin
                    if (back_half.size() == 0) begin
                        res.popped = front_half[front_half.size() - 1];
                        front_half.delete(front_half.size() - 1);
                    end else begin
                        res.popped = back_half[back_half.size() - 1];
                        back_half.delete(back_half.size() - 1);
                        if (front_half.size() > back_half.size() + 1) begin
                            back_half.insert(0, front_half[front_half.size() - 1]);
                            front_half.delete(front_half.size() - 1);
                        end
                    end
                end
                default: ;  // spare modes leave the queue alone
            endcase
        end
        res.occupancy = OCC_W'(front_half.size() + back_half.size());
    endtask

    always @(posedge i_clk) begin
        t_result want;
        t_result got;
        if (!i_rst_n) begin
            front_half.delete();
            back_half.delete();
            expected_results.delete();
        end else begin
            if (i_out.valid && i_out.ready) begin
                got.popped    = i_out.popped;
                got.status    = i_out.status;
                got.occupancy = i_out.occupancy;
                if (expected_results.size() == 0) begin
                    report($sformatf("result word with none expected: popped %0d status %0d",
                                     got.popped, got.status));
                end else begin
                    want = expected_results[0];
                    expected_results.delete(0);
                    if (got.popped !== want.popped)
                        report($sformatf("popped: got %0d, expected %0d",
                                         got.popped, want.popped));
                    if (got.status !== want.status)
                        report($sformatf("status: got %0d, expected %0d",
                                         got.status, want.status));
                    if (got.occupancy !== want.occupancy)
                        report($sformatf("occupancy: got %0d, expected %0d",
                                         got.occupancy, want.occupancy));
                end
            end
            if (i_in.valid && i_in.ready) begin
                apply_request(i_in.mode, i_in.value, want);
                expected_results.insert(expected_results.size(), want);
            end
        end
        o_pending = expected_results.size();
        o_level   = front_half.size() + back_half.size();
    end

endmodule

### bench/tb.sv
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the front/middle/back queue: a directed opening,
// then mixed, fill-to-full and drain traffic with random gaps and stalls on
// both channels. Checking is done by fmbq_monitor.
// ----------------------------------------------------------------------------
module tb;

    localparam int CAPACITY   = 1024;
    localparam int OCC_W      = 11;
    localparam int LONG_HOLD  = 150;
    localparam int DRAIN_TAIL = 8;

    localparam logic [fmbq_pkg::MODE_W-1:0]        MODE_SPARE_LO = 3'd6;
    localparam logic [fmbq_pkg::MODE_W-1:0]        MODE_SPARE_HI = 3'd7;
    localparam logic signed [fmbq_pkg::DATA_W-1:0] DATA_MIN      = 32'sh8000_0000;
    localparam logic signed [fmbq_pkg::DATA_W-1:0] DATA_MAX      = 32'sh7fff_ffff;

    logic i_clk;
    logic i_rst_n;
    logic steady;        // no random gaps on either side while set
    logic hold_off_req;  // asks the result side for one long stall
    int   fail_count;
    int   pending;
    int   level;

    fmbq_in_if                  req_if ();
    fmbq_out_if #(.OCC_W(OCC_W)) res_if ();

    front_middle_back_queue #(.CAPACITY(CAPACITY)) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (req_if),
        .o_out   (res_if)
    );

    fmbq_monitor #(.CAPACITY(CAPACITY), .OCC_W(OCC_W)) u_monitor (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (req_if),
        .i_out        (res_if),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_level      (level)
    );

    always begin
        i_clk = 1'b0;
        #2;
        i_clk = 1'b1;
        #2;
    end

    initial begin
        #4_000_000;
        $display("[front_middle_back_queue] ERROR");
        $finish;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(4, 24);
    endfunction

    function automatic logic [fmbq_pkg::MODE_W-1:0] pick_mode(input int push_pct);
        logic [fmbq_pkg::MODE_W-1:0] base;
        if ($urandom_range(0, 99) < 2)
            return $urandom_range(0, 1) ? MODE_SPARE_LO : MODE_SPARE_HI;
        base = ($urandom_range(0, 99) < push_pct) ? fmbq_pkg::MODE_PUSH_FRONT
                                                   : fmbq_pkg::MODE_POP_FRONT;
        return base + fmbq_pkg::MODE_W'($urandom_range(0, 2));
    endfunction

    function automatic logic signed [fmbq_pkg::DATA_W-1:0] pick_value();
        case ($urandom_range(0, 19))
            0:       return DATA_MIN;
            1:       return DATA_MAX;
            2:       return '0;
            3:       return -32'sd1;
            default: return $urandom();
        endcase
    endfunction

    // called at a falling edge; returns at the falling edge after acceptance
    task automatic drive_word(input logic [fmbq_pkg::MODE_W-1:0] mode,
                              input logic signed [fmbq_pkg::DATA_W-1:0] value);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        req_if.valid <= 1'b1;
        req_if.mode  <= mode;
        req_if.value <= value;
        do @(posedge i_clk); while (!req_if.ready);
        @(negedge i_clk);
    endtask

    // result side
    initial begin
        int   gap;
        logic held;
        held         = 1'b0;
        res_if.ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            res_if.ready <= 1'b1;
            repeat ($urandom_range(1, 10)) @(negedge i_clk);
            if (hold_off_req && !held) begin
                held = 1'b1;
                res_if.ready <= 1'b0;
                repeat (LONG_HOLD) @(negedge i_clk);
            end else begin
                gap = pick_gap();
                if (gap > 0) begin
                    res_if.ready <= 1'b0;
                    repeat (gap) @(negedge i_clk);
                end
            end
        end
    end

    // request side
    initial begin
        int   n;
        logic hold_done;
        i_rst_n      = 1'b0;
        steady       = 1'b0;
        hold_off_req = 1'b0;
        hold_done    = 1'b0;
        req_if.valid = 1'b0;
        req_if.mode  = fmbq_pkg::MODE_PUSH_FRONT;
        req_if.value = '0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // empty queue, spare modes, then the back-push and back-pop corner
        // where the back half is empty
        drive_word(fmbq_pkg::MODE_POP_FRONT, DATA_MAX);
        drive_word(fmbq_pkg::MODE_POP_MIDDLE, '0);
        drive_word(fmbq_pkg::MODE_POP_BACK, DATA_MIN);
        drive_word(MODE_SPARE_LO, DATA_MAX);
        drive_word(MODE_SPARE_HI, -32'sd1);
        drive_word(fmbq_pkg::MODE_PUSH_BACK, DATA_MIN);
        drive_word(fmbq_pkg::MODE_POP_BACK, '0);
        drive_word(fmbq_pkg::MODE_PUSH_MIDDLE, DATA_MAX);
        drive_word(fmbq_pkg::MODE_PUSH_FRONT, '0);
        drive_word(fmbq_pkg::MODE_PUSH_BACK, -32'sd1);
        drive_word(fmbq_pkg::MODE_PUSH_MIDDLE, 32'sh5555_5555);
        drive_word(fmbq_pkg::MODE_PUSH_FRONT, 32'shaaaa_aaaa);
        drive_word(fmbq_pkg::MODE_PUSH_BACK, 32'sd1);
        drive_word(MODE_SPARE_LO, DATA_MIN);
        drive_word(fmbq_pkg::MODE_POP_MIDDLE, '0);
        drive_word(fmbq_pkg::MODE_POP_BACK, '0);
        drive_word(fmbq_pkg::MODE_POP_FRONT, '0);
        drive_word(fmbq_pkg::MODE_POP_MIDDLE, '0);
        drive_word(fmbq_pkg::MODE_POP_BACK, '0);
        drive_word(fmbq_pkg::MODE_POP_FRONT, '0);
        drive_word(fmbq_pkg::MODE_POP_MIDDLE, '0);
        drive_word(fmbq_pkg::MODE_PUSH_MIDDLE, 32'sd7);
        drive_word(fmbq_pkg::MODE_POP_MIDDLE, '0);
        drive_word(fmbq_pkg::MODE_POP_FRONT, '0);

        // balanced traffic near empty
        for (n = 0; n < 150; n++) begin
            if (n % 50 == 0)
                steady = ($urandom_range(0, 3) == 0);
            drive_word(pick_mode(50), pick_value());
        end

        // let every result word drain before filling up
        req_if.valid <= 1'b0;
        do @(negedge i_clk); while (pending != 0);

        n = 0;
        while (level < CAPACITY) begin
            if (n % 100 == 0)
                steady = ($urandom_range(0, 3) == 0);
            if (level >= 400 && !hold_done) begin
                hold_off_req = 1'b1;
                hold_done    = 1'b1;
            end
            drive_word(pick_mode(95), pick_value());
            n++;
        end
        steady = 1'b0;
        drive_word(fmbq_pkg::MODE_PUSH_FRONT, pick_value());
        drive_word(fmbq_pkg::MODE_PUSH_MIDDLE, pick_value());
        drive_word(fmbq_pkg::MODE_PUSH_BACK, pick_value());
        repeat (9) drive_word(pick_mode(90), pick_value());

        for (n = 0; n < 180; n++)
            drive_word(pick_mode(20), pick_value());

        req_if.valid <= 1'b0;
        do @(negedge i_clk); while (pending != 0);
        repeat (DRAIN_TAIL) @(negedge i_clk);

        if (fail_count == 0)
            $display("[front_middle_back_queue] OK");
        else
            $display("[front_middle_back_queue] ERROR");
        $finish;
    end

endmodule

### sim.f
hdl/fmbq_pkg.sv
hdl/fmbq_if.sv
hdl/front_middle_back_queue.sv
bench/fmbq_monitor.sv
bench/tb.sv
